// File: sv/mxst_pkg.sv
// ----------------------------------------------------------------------------
// mxst_pkg
// Types and constants shared by the maximum-XOR run tracker and its checker.
// ----------------------------------------------------------------------------
package mxst_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_QUERY,
      ST_WALK,
      ST_ALLOC,
      ST_EMIT
   } state_type;

   localparam int DATA_W = 32;
   localparam int BEST_W = 31;
   localparam int RSP_W  = BEST_W + 1;

   localparam logic [BEST_W-1:0] BEST_MAX = 31'h7FFF_FFFF;

endpackage

// File: sv/max_xor_subarray_trie.sv
// ----------------------------------------------------------------------------
// max_xor_subarray_trie
// Largest XOR over any contiguous run of a word stream, via a binary trie.
// ----------------------------------------------------------------------------
// Each accepted word updates a running prefix XOR; the block then walks a
// binary trie of earlier prefixes one key bit per cycle to find the best
// partner, and walks it again to insert the new prefix, allocating the
// missing nodes one per cycle. One result word follows each input word.
// A new word is taken only in the idle state, once the result word of the
// last one is in the output register; a word with the restart flag set first
// reseeds the trie, and a result word not yet taken at the output holds the
// block in its last step. The single node memory serves one trie level per
// cycle to both walks. After reset the block seeds the trie with prefix zero
// before req_tready rises. Once the node pool runs dry an insert is dropped
// whole and the overflow flag stays set until reset.
// ----------------------------------------------------------------------------
module max_xor_subarray_trie
   import mxst_pkg::*;
#(
   parameter int KEY_BITS  = 32,
   parameter int NODE_POOL = 65536
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [DATA_W-1:0] req_tdata,   // [31:0] value
   input  logic              req_tuser,   // [0] restart
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_W-1:0]  rsp_tdata    // [30:0] best, [31] overflow
);

   localparam int IDX_W  = $clog2(NODE_POOL);
   localparam int USED_W = $clog2(NODE_POOL + 1);
   localparam int CNT_W  = $clog2(KEY_BITS + 1);
   localparam int CAND_W = KEY_BITS - 1;
   localparam int WORD_W = 2 * IDX_W;
   localparam int SUM_W  = USED_W + 1;

   // node word: {one_child, zero_child}, zero meaning no child
   logic [WORD_W-1:0] node_mem [NODE_POOL];
   logic [WORD_W-1:0] rd_data_ff;
   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [WORD_W-1:0] wr_data;

   state_type           state_ff, state_in;
   logic                seed_ff, seed_in;
   logic                item_ff, item_in;
   logic                fresh_ff, fresh_in;
   logic [IDX_W-1:0]    nd_ff, nd_in;
   logic [USED_W-1:0]   used_ff, used_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [DATA_W-1:0]   prefix_ff, prefix_in;
   logic [DATA_W-1:0]   value_ff, value_in;
   logic [CAND_W-1:0]   best_ff, best_in;
   logic [CAND_W-1:0]   cand_ff, cand_in;
   logic                ok_ff, ok_in;
   logic                gt_ff, gt_in;
   logic                lt_ff, lt_in;
   logic                pool_full_ff, pool_full_in;
   logic                rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_W-1:0]    rsp_tdata_ff, rsp_tdata_in;

   logic                key_bit;
   logic [KEY_BITS-1:0] key_rot;
   logic [CAND_W-1:0]   best_rot;
   logic [IDX_W-1:0]    child_zero;
   logic [IDX_W-1:0]    child_one;
   logic                sign_level;
   logic                last_level;
   logic                want;
   logic                took;
   logic [IDX_W-1:0]    c_want;
   logic [IDX_W-1:0]    c_alt;
   logic [IDX_W-1:0]    c_next;
   logic [IDX_W-1:0]    c_walk;
   logic                dead;
   logic                xbit;
   logic                pool_short;
   logic [WORD_W-1:0]   parent_word;
   logic [IDX_W-1:0]    new_node;
   logic [BEST_W-1:0]   best_out;

   assign key_bit    = key_ff[KEY_BITS-1];
   assign key_rot    = {key_ff[KEY_BITS-2:0], key_ff[KEY_BITS-1]};
   assign best_rot   = {best_ff[CAND_W-2:0], best_ff[CAND_W-1]};
   assign child_zero = rd_data_ff[IDX_W-1:0];
   assign child_one  = rd_data_ff[WORD_W-1:IDX_W];
   assign sign_level = (cnt_ff == CNT_W'(KEY_BITS));
   assign last_level = (cnt_ff == CNT_W'(1));

   // query step: same bit at the sign position, opposite bit below it
   assign want   = sign_level ? key_bit : ~key_bit;
   assign c_want = want ? child_one : child_zero;
   assign c_alt  = want ? child_zero : child_one;
   assign took   = (c_want != '0) ? want : ~want;
   assign c_next = (c_want != '0) ? c_want : c_alt;
   assign dead   = (c_want == '0) && (c_alt == '0);
   assign xbit   = key_bit ^ took;

   assign c_walk = key_bit ? child_one : child_zero;

   assign pool_short = (SUM_W'(used_ff) + SUM_W'(cnt_ff)) > SUM_W'(NODE_POOL);

   assign parent_word = fresh_ff ? '0 : rd_data_ff;
   assign new_node    = used_ff[IDX_W-1:0];

   assign best_out = (best_ff > CAND_W'(BEST_MAX)) ? BEST_MAX : BEST_W'(best_ff);

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   always_comb begin
      state_in      = state_ff;
      seed_in       = seed_ff;
      item_in       = item_ff;
      fresh_in      = fresh_ff;
      nd_in         = nd_ff;
      used_in       = used_ff;
      cnt_in        = cnt_ff;
      key_in        = key_ff;
      prefix_in     = prefix_ff;
      value_in      = value_ff;
      best_in       = best_ff;
      cand_in       = cand_ff;
      ok_in         = ok_ff;
      gt_in         = gt_ff;
      lt_in         = lt_ff;
      pool_full_in  = pool_full_ff;
      rsp_tvalid_in = rsp_tvalid_ff & ~rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rd_en         = 1'b0;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = nd_ff;
      wr_data       = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               value_in = req_tdata;
               item_in  = 1'b1;
               if (req_tuser) begin
                  // drop the trie and reseed it with prefix zero
                  prefix_in = '0;
                  best_in   = '0;
                  used_in   = USED_W'(1);
                  nd_in     = '0;
                  fresh_in  = 1'b1;
                  key_in    = '0;
                  cnt_in    = CNT_W'(KEY_BITS);
                  seed_in   = 1'b1;
                  state_in  = ST_ALLOC;
               end else begin
                  state_in = ST_LOAD;
               end
            end
         end

         ST_LOAD: begin
            prefix_in = prefix_ff ^ value_ff;
            key_in    = KEY_BITS'({{DATA_W{prefix_in[DATA_W-1]}}, prefix_in});
            cnt_in    = CNT_W'(KEY_BITS);
            ok_in     = 1'b1;
            gt_in     = 1'b0;
            lt_in     = 1'b0;
            rd_en     = 1'b1;
            rd_addr   = '0;
            state_in  = ST_QUERY;
         end

         ST_QUERY: begin
            ok_in = ok_ff & ~dead & ~(sign_level & xbit);
            if (!sign_level) begin
               cand_in = {cand_ff[CAND_W-2:0], xbit};
               best_in = best_rot;
               if (!gt_ff && !lt_ff) begin
                  gt_in = xbit & ~best_ff[CAND_W-1];
                  lt_in = ~xbit & best_ff[CAND_W-1];
               end
            end
            key_in  = key_rot;
            cnt_in  = cnt_ff - CNT_W'(1);
            rd_en   = 1'b1;
            rd_addr = c_next;
            if (last_level) begin
               if (ok_in && gt_in) begin
                  best_in = cand_in;
               end
               // restart from the root for the insert walk
               cnt_in   = CNT_W'(KEY_BITS);
               nd_in    = '0;
               rd_addr  = '0;
               state_in = ST_WALK;
            end
         end

         ST_WALK: begin
            if (c_walk != '0) begin
               nd_in   = c_walk;
               key_in  = key_rot;
               cnt_in  = cnt_ff - CNT_W'(1);
               rd_en   = 1'b1;
               rd_addr = c_walk;
               if (last_level) begin
                  state_in = ST_EMIT;
               end
            end else if (pool_short) begin
               pool_full_in = 1'b1;
               state_in     = ST_EMIT;
            end else begin
               fresh_in = 1'b0;
               state_in = ST_ALLOC;
            end
         end

         ST_ALLOC: begin
            wr_en   = 1'b1;
            wr_addr = nd_ff;
            wr_data = key_bit ? {new_node, parent_word[IDX_W-1:0]}
                              : {parent_word[WORD_W-1:IDX_W], new_node};
            nd_in    = new_node;
            fresh_in = 1'b1;
            used_in  = used_ff + USED_W'(1);
            key_in   = key_rot;
            cnt_in   = cnt_ff - CNT_W'(1);
            if (last_level) begin
               if (seed_ff) begin
                  seed_in  = 1'b0;
                  state_in = item_ff ? ST_LOAD : ST_IDLE;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end

         ST_EMIT: begin
            // hold until the output register is free
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {pool_full_ff, best_out};
               item_in       = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_ALLOC;
         seed_ff       <= 1'b1;
         item_ff       <= 1'b0;
         fresh_ff      <= 1'b1;
         nd_ff         <= '0;
         used_ff       <= USED_W'(1);
         cnt_ff        <= CNT_W'(KEY_BITS);
         key_ff        <= '0;
         prefix_ff     <= '0;
         best_ff       <= '0;
         pool_full_ff  <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         seed_ff       <= seed_in;
         item_ff       <= item_in;
         fresh_ff      <= fresh_in;
         nd_ff         <= nd_in;
         used_ff       <= used_in;
         cnt_ff        <= cnt_in;
         key_ff        <= key_in;
         prefix_ff     <= prefix_in;
         best_ff       <= best_in;
         pool_full_ff  <= pool_full_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff     <= value_in;
      cand_ff      <= cand_in;
      ok_ff        <= ok_in;
      gt_ff        <= gt_in;
      lt_ff        <= lt_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         node_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= node_mem[rd_addr];
      end
   end

endmodule

// File: sv/mxst_checker.sv
// ----------------------------------------------------------------------------
// mxst_checker
// Port-level checks on the maximum-XOR run tracker, bound to its top level.
// ----------------------------------------------------------------------------
module mxst_checker
   import mxst_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_tvalid,
   input logic              req_tready,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [RSP_W-1:0]  rsp_tdata
);

   logic [1:0] pending_ff, pending_in;
   logic       ovf_seen_ff, ovf_seen_in;
   logic       req_fire;
   logic       rsp_fire;

   assign req_fire = req_tvalid & req_tready;
   assign rsp_fire = rsp_tvalid & rsp_tready;

   // count words accepted but not yet answered
   always_comb begin
      pending_in  = pending_ff;
      ovf_seen_in = ovf_seen_ff | (rsp_fire & rsp_tdata[RSP_W-1]);
      if (req_fire && !rsp_fire) begin
         pending_in = pending_ff + 2'd1;
      end else if (!req_fire && rsp_fire) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff  <= '0;
         ovf_seen_ff <= 1'b0;
      end else begin
         pending_ff  <= pending_in;
         ovf_seen_ff <= ovf_seen_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pending_ff != 2'd0)
      else $error("result word without an accepted input word");

   a_bounded: assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd3)
      else $error("more than two words in flight");

   a_ovf_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && ovf_seen_ff |-> rsp_tdata[RSP_W-1])
      else $error("overflow flag cleared without reset");

endmodule

bind max_xor_subarray_trie mxst_checker u_mxst_checker (.*);

// File: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the maximum-XOR run tracker.
// ----------------------------------------------------------------------------
// A queue of words is filled up front: a directed opening, a random mix with
// occasional restarts, a long run of widely spread prefixes that grows the
// trie deep into the node pool, and a random tail. The driver and the
// monitor idle at random; once the monitor holds off for a long stretch so
// that the block backs up. Each accepted word runs through a trie model
// kept here, and every result word is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
   import mxst_pkg::*;

   localparam int KEY_BITS  = 32;
   localparam int NODE_POOL = 65536;
   localparam int LIMIT     = 2_500_000;
   localparam int RANDOM_WORDS = 600;
   localparam int FILL_WORDS   = 1000;
   localparam int TAIL_WORDS   = 150;
   localparam int CALM_WORDS   = 250;
   localparam int HOLD_AT      = 100;
   localparam int HOLD_CYCLES  = 500;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              restart;
   } word_type;

   typedef struct packed {
      logic [BEST_W-1:0] best;
      logic              overflow;
   } result_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [DATA_W-1:0] req_tdata = '0;   // [31:0] value
   logic              req_tuser = 1'b0; // [0] restart
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;        // [30:0] best, [31] overflow

   max_xor_subarray_trie #(
      .KEY_BITS  (KEY_BITS),
      .NODE_POOL (NODE_POOL)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Trie model
   // ------------------------------------------------------------------------
   int unsigned       zero_kid [NODE_POOL];
   int unsigned       one_kid  [NODE_POOL];
   int unsigned       nodes_used;
   logic [DATA_W-1:0] run_xor;
   logic [BEST_W-1:0] best_seen;
   logic              pool_full;

   function automatic void trie_insert(input logic [DATA_W-1:0] key);
      int unsigned nd;
      int unsigned kid;
      int          lvl;
      bit          found;
      nd = 0;
      lvl = KEY_BITS - 1;
      found = 1'b1;
      while (lvl >= 0 && found) begin
         kid = key[lvl] ? one_kid[nd] : zero_kid[nd];
         if (kid == 0) begin
            found = 1'b0;
         end else begin
            nd = kid;
            lvl--;
         end
      end
      // drop the whole insert if the missing levels do not fit
      if (nodes_used + lvl + 1 > NODE_POOL) begin
         pool_full = 1'b1;
      end else begin
         while (lvl >= 0) begin
            kid = nodes_used;
            nodes_used++;
            zero_kid[kid] = 0;
            one_kid[kid] = 0;
            if (key[lvl]) one_kid[nd] = kid;
            else zero_kid[nd] = kid;
            nd = kid;
            lvl--;
         end
      end
   endfunction

   function automatic void trie_reseed();
      zero_kid[0] = 0;
      one_kid[0] = 0;
      nodes_used = 1;
      run_xor = '0;
      best_seen = '0;
      trie_insert('0);
   endfunction

   function automatic result_type track_word(input logic [DATA_W-1:0] word,
                                             input logic restart);
      result_type        res;
      int unsigned       nd;
      int unsigned       kid;
      logic              want;
      logic              took;
      logic [DATA_W-1:0] path;
      bit                ok;
      if (restart) trie_reseed();
      run_xor = run_xor ^ word;
      // best partner: same bit at the sign, opposite bit below it
      nd = 0;
      path = '0;
      ok = 1'b1;
      for (int i = KEY_BITS - 1; i >= 0 && ok; i--) begin
         want = (i == KEY_BITS - 1) ? run_xor[i] : ~run_xor[i];
         took = want;
         kid = want ? one_kid[nd] : zero_kid[nd];
         if (kid == 0) begin
            took = ~want;
            kid = took ? one_kid[nd] : zero_kid[nd];
            if (kid == 0) ok = 1'b0;
         end
         path = {path[DATA_W-2:0], took};
         nd = kid;
      end
      path = path ^ run_xor;
      if (ok && !path[DATA_W-1] && path[BEST_W-1:0] > best_seen)
         best_seen = path[BEST_W-1:0];
      trie_insert(run_xor);
      res.best = best_seen;
      res.overflow = pool_full;
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   word_type   word_queue[$];
   result_type best_due[$];
   int         total_words;
   int         words_sent;
   int         results_seen;
   int         fail_count;
   int         cycle_count;

   task automatic queue_word(input logic [DATA_W-1:0] value, input logic restart);
      word_type w;
      w.value = value;
      w.restart = restart;
      word_queue.push_back(w);
   endtask

   function automatic logic [DATA_W-1:0] pick_value();
      logic [DATA_W-1:0] extremes [4];
      extremes = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
      case ($urandom_range(0, 7))
         4: return DATA_W'($urandom_range(0, 15));
         5: return -DATA_W'($urandom_range(1, 16));
         6: return extremes[$urandom_range(0, 3)];
         7: return DATA_W'(1) << $urandom_range(0, DATA_W - 1);
         default: return DATA_W'($urandom);
      endcase
   endfunction

   initial begin
      logic [DATA_W-1:0] fill_pfx;
      logic [DATA_W-1:0] key;
      logic [11:0]       k12;
      logic [11:0]       top;

      // directed opening: extremes, lone signs, repeated prefixes
      queue_word(32'h0000_0000, 1'b0);
      queue_word(32'h7FFF_FFFF, 1'b0);
      queue_word(32'h8000_0000, 1'b0);
      queue_word(32'hFFFF_FFFF, 1'b0);
      queue_word(32'h8000_0000, 1'b1);
      queue_word(32'h0000_0001, 1'b0);
      queue_word(32'hFFFF_FFFF, 1'b1);
      queue_word(32'h0000_0001, 1'b0);
      queue_word(32'h0000_0000, 1'b0);
      queue_word(32'h0000_0000, 1'b0);
      queue_word(32'h5555_5555, 1'b1);
      queue_word(32'hAAAA_AAAA, 1'b0);
      queue_word(32'h0F0F_0F0F, 1'b0);
      queue_word(32'hF0F0_F0F0, 1'b0);
      queue_word(32'h8000_0000, 1'b0);
      queue_word(32'h8000_0000, 1'b0);
      queue_word(32'h7FFF_FFFF, 1'b1);
      queue_word(32'h7FFF_FFFF, 1'b0);
      queue_word(32'h0000_0001, 1'b0);
      queue_word(32'h0000_0002, 1'b0);
      queue_word(32'h0000_0004, 1'b0);
      queue_word(32'hFFFF_FFF8, 1'b0);

      for (int n = 0; n < RANDOM_WORDS; n++)
         queue_word(pick_value(), $urandom_range(0, 39) == 0);

      // spread prefixes over the top levels so that each insert takes many
      // fresh nodes
      fill_pfx = '0;
      for (int k = 1; k <= FILL_WORDS; k++) begin
         k12 = 12'(k);
         for (int b = 0; b < 12; b++) top[b] = k12[11-b];
         key = {top, 20'($urandom)};
         queue_word(key ^ fill_pfx, k == 1);
         fill_pfx = key;
      end

      // random tail with a forced restart
      for (int n = 0; n < TAIL_WORDS; n++)
         queue_word(pick_value(), n == 40 || $urandom_range(0, 29) == 0);

      total_words = word_queue.size();
      words_sent = 0;
      results_seen = 0;
      fail_count = 0;
      trie_reseed();
      pool_full = 1'b0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (words_sent != total_words) @(posedge clock);
      while (best_due.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);

      if (fail_count == 0 && best_due.size() == 0) begin
         $display("max_xor_subarray_trie: match");
      end else begin
         $display("max_xor_subarray_trie: mismatch");
      end
      $finish;
   end

   // ------------------------------------------------------------------------
   // Driver
   // ------------------------------------------------------------------------
   int       send_gap;
   word_type next_word;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            best_due.push_back(track_word(req_tdata, req_tuser));
            words_sent++;
         end
         // hold the word until it is taken
         if (!(req_tvalid && !req_tready)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (word_queue.size() == 0) begin
               req_tvalid <= 1'b0;
            end else if (word_queue.size() > CALM_WORDS && $urandom_range(0, 15) == 0) begin
               send_gap = $urandom_range(1, 11) - 1;
               req_tvalid <= 1'b0;
            end else begin
               next_word = word_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= next_word.value;
               req_tuser <= next_word.restart;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor
   // ------------------------------------------------------------------------
   int         hold_left;
   bit         hold_done;
   result_type due;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left = 0;
         hold_done = 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (best_due.size() == 0) begin
               $display("%0t: result word with nothing due, got best %h overflow %b",
                        $time, rsp_tdata[BEST_W-1:0], rsp_tdata[BEST_W]);
               fail_count++;
            end else begin
               due = best_due.pop_front();
               if (rsp_tdata[BEST_W-1:0] !== due.best) begin
                  $display("%0t: best expected %h got %h",
                           $time, due.best, rsp_tdata[BEST_W-1:0]);
                  fail_count++;
               end
               if (rsp_tdata[BEST_W] !== due.overflow) begin
                  $display("%0t: overflow expected %b got %b",
                           $time, due.overflow, rsp_tdata[BEST_W]);
                  fail_count++;
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!hold_done && results_seen == HOLD_AT) begin
            // long hold-off: let the block back up and stall its input
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_tready <= 1'b0;
         end else if (word_queue.size() > CALM_WORDS && $urandom_range(0, 15) == 0) begin
            hold_left = $urandom_range(1, 11) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == LIMIT) begin
         $display("max_xor_subarray_trie: mismatch");
         $finish;
      end
   end

endmodule
